@@ hdl/assert_macros.svh @@
// ------------------------------------------------------------------------
// assertion macros
// concurrent assertion forms used by the checker file
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, ignored while reset is held
`define ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/mns_pkg.sv @@
// ------------------------------------------------------------------------
// mns_pkg
// shared types, codes and note tables of the melody note sequencer
// ------------------------------------------------------------------------
package mns_pkg;

    localparam int unsigned SONG_DEPTH_DEF = 256;
    localparam int unsigned CRYSTAL_HZ_DEF = 33177600;

    localparam int unsigned NUM_TONES = 22;
    localparam int unsigned MACHINE_DIV = 12;

    // note table index of the rest entry
    localparam logic [4:0] REST_IDX = 5'd21;

    // song entry codes
    localparam logic [7:0] FIRST_CODE = 8'd1;
    localparam logic [7:0] LAST_CODE  = 8'd22;
    localparam logic [7:0] END_CODE   = 8'hFF;

    localparam logic [15:0] HALF_RESET = 16'd256;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_START = 2'd2,
        OP_STOP  = 2'd3
    } opcode_t;

    typedef enum logic {
        ST_IDLE,
        ST_LOAD
    } state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic exec;     // apply the accepted beat
        logic load;     // decode the fetched song entry
        logic produce;  // capture the result beat
    } dp_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic need_fetch;  // accepted tick must read the song memory
    } dp_status_t;

    // tone frequencies in hz: middle, high, low octave, rest
    localparam logic [10:0] TONE_FREQ [NUM_TONES] = '{
        11'd523,  11'd587,  11'd659,  11'd698,  11'd784,  11'd880,  11'd988,
        11'd1047, 11'd1175, 11'd1319, 11'd1397, 11'd1568, 11'd1760, 11'd1976,
        11'd262,  11'd294,  11'd330,  11'd349,  11'd392,  11'd440,  11'd494,
        11'd300
    };

endpackage

@@ hdl/mns_ctrl.sv @@
// ------------------------------------------------------------------------
// mns_ctrl
// handshake and sequencing control of the melody note sequencer
// ------------------------------------------------------------------------
module mns_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output mns_pkg::dp_cmd_t       cmd,
    input  mns_pkg::dp_status_t    status
);

    mns_pkg::state_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;
    logic            out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;

    // outputs
    always_comb begin
        s_tready    = (state_reg == mns_pkg::ST_IDLE) && out_free;
        cmd.exec    = s_tvalid && s_tready;
        cmd.load    = (state_reg == mns_pkg::ST_LOAD);
        cmd.produce = (cmd.exec && !status.need_fetch) || cmd.load;
        if (cmd.produce) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mns_pkg::ST_IDLE: begin
                if (s_tvalid && s_tready && status.need_fetch) begin
                    state_next = mns_pkg::ST_LOAD;
                end
            end
            mns_pkg::ST_LOAD: begin
                state_next = mns_pkg::ST_IDLE;
            end
            default: begin
                state_next = mns_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mns_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

@@ hdl/mns_datapath.sv @@
// ------------------------------------------------------------------------
// mns_datapath
// song memory, tone timer and note sequencer registers
// ------------------------------------------------------------------------
module mns_datapath #(
    parameter int unsigned SONG_DEPTH = mns_pkg::SONG_DEPTH_DEF,
    parameter int unsigned CRYSTAL_HZ = mns_pkg::CRYSTAL_HZ_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mns_pkg::dp_cmd_t      cmd,
    output mns_pkg::dp_status_t   status,
    input  mns_pkg::opcode_t      opcode,
    input  logic [7:0]            address,
    input  logic [7:0]            note_code,
    input  logic [7:0]            beat_length,
    output logic [15:0]           out_data
);

    localparam int unsigned IDX_W    = $clog2(SONG_DEPTH);
    localparam int unsigned XTAL_DIV = CRYSTAL_HZ / mns_pkg::MACHINE_DIV;

    // half-period reload per note, in machine ticks
    localparam logic [15:0] HALF_TBL [mns_pkg::NUM_TONES] = '{
        16'(XTAL_DIV / (2 * mns_pkg::TONE_FREQ[0])),
        16'(XTAL_DIV / (2 * mns_pkg::TONE_FREQ[1])),
        16'(XTAL_DIV / (2 * mns_pkg::TONE_FREQ[2])),
        16'(XTAL_DIV / (2 * mns_pkg::TONE_FREQ[3])),
        16'(XTAL_DIV / (2 * mns_pkg::TONE_FREQ[4])),
        16'(XTAL_DIV / (2 * mns_pkg::TONE_FREQ[5])),
        16'(XTAL_DIV / (2 * mns_pkg::TONE_FREQ[6])),
        16'(XTAL_DIV / (2 * mns_pkg::TONE_FREQ[7])),
        16'(XTAL_DIV / (2 * mns_pkg::TONE_FREQ[8])),
        16'(XTAL_DIV / (2 * mns_pkg::TONE_FREQ[9])),
        16'(XTAL_DIV / (2 * mns_pkg::TONE_FREQ[10])),
        16'(XTAL_DIV / (2 * mns_pkg::TONE_FREQ[11])),
        16'(XTAL_DIV / (2 * mns_pkg::TONE_FREQ[12])),
        16'(XTAL_DIV / (2 * mns_pkg::TONE_FREQ[13])),
        16'(XTAL_DIV / (2 * mns_pkg::TONE_FREQ[14])),
        16'(XTAL_DIV / (2 * mns_pkg::TONE_FREQ[15])),
        16'(XTAL_DIV / (2 * mns_pkg::TONE_FREQ[16])),
        16'(XTAL_DIV / (2 * mns_pkg::TONE_FREQ[17])),
        16'(XTAL_DIV / (2 * mns_pkg::TONE_FREQ[18])),
        16'(XTAL_DIV / (2 * mns_pkg::TONE_FREQ[19])),
        16'(XTAL_DIV / (2 * mns_pkg::TONE_FREQ[20])),
        16'(XTAL_DIV / (2 * mns_pkg::TONE_FREQ[21]))
    };

    // byte address to memory row, wrapping at the song depth
    typedef logic [IDX_W-1:0] row_map_t [256];

    function automatic row_map_t build_row_map();
        row_map_t    map;
        int unsigned v;
        for (int i = 0; i < 256; i++) begin
            v = i;
            for (int k = 0; k < 256; k++) begin
                if (v >= SONG_DEPTH) begin
                    v = v - SONG_DEPTH;
                end
            end
            map[i] = IDX_W'(v);
        end
        return map;
    endfunction

    localparam row_map_t ROW_MAP = build_row_map();

    logic [15:0] song_mem [SONG_DEPTH];
    logic [15:0] rd_data_reg;
    logic        rd_en, wr_en;

    logic [7:0]  ptr_reg, ptr_next;
    logic [16:0] timer_reg, timer_next;
    logic [16:0] span_reg, span_next;
    logic [16:0] sound_reg, sound_next;
    logic [15:0] half_reg, half_next;
    logic [15:0] pc_reg, pc_next;
    logic [4:0]  note_sel_reg, note_sel_next;
    logic        en_reg, en_next;
    logic        pin_reg, pin_next;
    logic        active_reg, active_next;
    logic        done;
    logic [15:0] out_data_reg;

    logic        expire;
    logic [16:0] timer_inc;
    logic [7:0]  ent_code, ent_beat;
    logic [4:0]  ent_idx;
    logic [18:0] span_prod;
    logic [16:0] new_span;

    assign expire    = (pc_reg <= 16'd1);
    assign timer_inc = timer_reg + 17'd1;
    assign ent_code  = rd_data_reg[15:8];
    assign ent_beat  = rd_data_reg[7:0];

    // codes outside the note range play as a rest
    assign ent_idx = (ent_code >= mns_pkg::FIRST_CODE && ent_code <= mns_pkg::LAST_CODE)
                     ? 5'(ent_code - mns_pkg::FIRST_CODE) : mns_pkg::REST_IDX;
    assign span_prod = 19'(ent_beat) * 19'(mns_pkg::TONE_FREQ[ent_idx]);
    assign new_span  = span_prod[18:2];

    assign status.need_fetch = (opcode == mns_pkg::OP_TICK) && expire && active_reg
                               && (timer_reg == 17'd0);

    always_comb begin
        ptr_next      = ptr_reg;
        timer_next    = timer_reg;
        span_next     = span_reg;
        sound_next    = sound_reg;
        half_next     = half_reg;
        pc_next       = pc_reg;
        note_sel_next = note_sel_reg;
        en_next       = en_reg;
        pin_next      = pin_reg;
        active_next   = active_reg;
        done          = 1'b0;
        rd_en         = 1'b0;
        wr_en         = 1'b0;

        if (cmd.exec) begin
            case (opcode)
                mns_pkg::OP_TICK: begin
                    if (expire) begin
                        pc_next  = half_reg;
                        pin_next = en_reg ? !pin_reg : 1'b1;
                        if (active_reg) begin
                            if (timer_reg == 17'd0) begin
                                rd_en = 1'b1;
                            end else if (timer_reg >= span_reg) begin
                                timer_next = '0;
                                ptr_next   = ptr_reg + 8'd1;
                            end else begin
                                timer_next = timer_inc;
                                if (timer_inc == sound_reg) begin
                                    en_next = 1'b0;
                                end
                            end
                        end
                    end else begin
                        pc_next = pc_reg - 16'd1;
                    end
                end
                mns_pkg::OP_WRITE: begin
                    wr_en = 1'b1;
                end
                mns_pkg::OP_START: begin
                    ptr_next    = address;
                    timer_next  = '0;
                    active_next = 1'b1;
                end
                mns_pkg::OP_STOP: begin
                    active_next = 1'b0;
                    timer_next  = '0;
                    en_next     = 1'b0;
                end
                default: begin
                end
            endcase
        end

        if (cmd.load) begin
            if (ent_code == mns_pkg::END_CODE) begin
                active_next = 1'b0;
                en_next     = 1'b0;
                done        = 1'b1;
            end else begin
                note_sel_next = ent_idx;
                half_next     = HALF_TBL[ent_idx];
                span_next     = new_span;
                sound_next    = new_span - {2'b00, new_span[16:2]};
                en_next       = (ent_idx != mns_pkg::REST_IDX);
                timer_next    = 17'd1;
            end
        end
    end

    // song memory, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            song_mem[ROW_MAP[address]] <= {note_code, beat_length};
        end
        if (rd_en) begin
            rd_data_reg <= song_mem[ROW_MAP[ptr_reg]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.produce) begin
            out_data_reg <= {7'd0, note_sel_next, done, active_next, en_next, pin_next};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg      <= '0;
            timer_reg    <= '0;
            span_reg     <= '0;
            sound_reg    <= '0;
            half_reg     <= mns_pkg::HALF_RESET;
            pc_reg       <= mns_pkg::HALF_RESET;
            note_sel_reg <= '0;
            en_reg       <= 1'b1;
            pin_reg      <= 1'b1;
            active_reg   <= 1'b0;
        end else begin
            ptr_reg      <= ptr_next;
            timer_reg    <= timer_next;
            span_reg     <= span_next;
            sound_reg    <= sound_next;
            half_reg     <= half_next;
            pc_reg       <= pc_next;
            note_sel_reg <= note_sel_next;
            en_reg       <= en_next;
            pin_reg      <= pin_next;
            active_reg   <= active_next;
        end
    end

    assign out_data = out_data_reg;

endmodule

@@ hdl/melody_note_sequencer.sv @@
// ------------------------------------------------------------------------
// melody_note_sequencer
// square-wave melody player driven by tick, write, start and stop beats
// ------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                      | tuser
// s_      | in  | address, note_code, beat_length (24 b)  | opcode (2 b)
// m_      | out | buzzer_level, tone_on, playing,         | -
//         |     | song_done, current_note (9 b in 16 b)   |
//
// a tick that runs out the half-period while a new song entry is due (first
// note after start, or the note after one that just ended) goes through the
// load state, which waits for the registered song memory read
// a new beat is taken while no song memory read is pending and the
// result register is empty or being read
// aresetn is synchronous; the song memory is not cleared and holds
// garbage until written, so no startup sweep is needed
// a stall on m_ holds the result and blocks s_ until it is taken
// ------------------------------------------------------------------------
module melody_note_sequencer #(
    parameter int unsigned SONG_DEPTH = mns_pkg::SONG_DEPTH_DEF,
    parameter int unsigned CRYSTAL_HZ = mns_pkg::CRYSTAL_HZ_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // address, note_code, beat_length
    input  logic [1:0]  s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // buzzer_level, tone_on, playing, song_done,
                                   // current_note, zero pad
);

    mns_pkg::dp_cmd_t    cmd;
    mns_pkg::dp_status_t status;

    // controller: accept, memory fetch wait and result register valid
    mns_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    // datapath: song memory, half-period timer, note sequencer
    mns_datapath #(
        .SONG_DEPTH (SONG_DEPTH),
        .CRYSTAL_HZ (CRYSTAL_HZ)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .opcode      (mns_pkg::opcode_t'(s_tuser)),
        .address     (s_tdata[7:0]),
        .note_code   (s_tdata[15:8]),
        .beat_length (s_tdata[23:16]),
        .out_data    (m_tdata)
    );

endmodule

@@ hdl/mns_checker.sv @@
// ------------------------------------------------------------------------
// mns_checker
// port-level checks of the melody note sequencer, bound to the top level
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module mns_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // result beat holds until taken
    `ASSERT_RST(a_m_hold, aclk, aresetn, (m_tvalid && !m_tready |=> m_tvalid), "m_tvalid dropped")
    `ASSERT_RST(a_m_stable, aclk, aresetn, (m_tvalid && !m_tready |=> $stable(m_tdata)), "m_tdata moved")
    // no beat taken while a result is stuck
    `ASSERT_RST(a_no_overrun, aclk, aresetn, (s_tvalid && s_tready |-> !m_tvalid || m_tready), "overrun")
    // end of song leaves the player stopped and silent
    `ASSERT_RST(a_done_stops, aclk, aresetn, (m_tvalid && m_tdata[3] |-> !m_tdata[2] && !m_tdata[1]), "done but playing")
    // note index stays inside the tone table
    `ASSERT_RST(a_note_range, aclk, aresetn, (m_tvalid |-> m_tdata[8:4] <= mns_pkg::REST_IDX), "bad note index")

endmodule

bind melody_note_sequencer mns_checker u_checker (.*);

@@ tb/tb_melody_note_sequencer.sv @@
`timescale 1ns / 100ps
// ------------------------------------------------------------------------
// tb_melody_note_sequencer
// drives tick, write, start and stop beats into the melody player and
// checks every status beat against a cycle-free model of the sequencer,
// under phases of steady flow, source gaps and sink back-pressure
// ------------------------------------------------------------------------
module tb_melody_note_sequencer;

    localparam int unsigned RESET_CYCLES = 7;
    localparam int unsigned TICK_HZ = mns_pkg::CRYSTAL_HZ_DEF / mns_pkg::MACHINE_DIV;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned MAX_REPORTS = 40;
    localparam int unsigned RUN_LIMIT_NS = 1_000_000;
    // ticks sent by the directed opening, taken off the reset half-period
    localparam int unsigned DIRECTED_TICKS = 8;
    // ticks sent after the end marker is due
    localparam int unsigned TAIL_TICKS = 40;

    // traffic phases
    localparam logic [1:0] PH_STEADY = 2'd0;
    localparam logic [1:0] PH_SRC_GAPS = 2'd1;
    localparam logic [1:0] PH_SINK_STALL = 2'd2;
    localparam logic [1:0] PH_BOTH_LIGHT = 2'd3;

    // one input beat plus the traffic phase it is sent under
    typedef struct packed {
        mns_pkg::opcode_t op;
        logic [7:0]       addr;
        logic [7:0]       code;
        logic [7:0]       beat;
        logic [1:0]       phase;
    } cmd_t;

    // result beat, lowest bit first from the bottom
    typedef struct packed {
        logic [6:0] pad;
        logic [4:0] note;
        logic       done;
        logic       playing;
        logic       tone;
        logic       level;
    } status_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = mns_pkg::OP_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    cmd_t    cmd_backlog[$];
    status_t expected_status[$];
    cmd_t    cur_cmd;
    logic [1:0] cur_phase = PH_STEADY;

    // model of the player state
    logic [15:0] tune_mem [256];
    logic [7:0]  play_ptr = '0;
    logic [16:0] note_count = '0;
    logic [16:0] note_len = '0;
    logic [16:0] sound_len = '0;
    logic [15:0] half_len = mns_pkg::HALF_RESET;
    logic [15:0] half_count = mns_pkg::HALF_RESET;
    logic [4:0]  note_idx = '0;
    logic        tone_en = 1'b1;
    logic        pin_lvl = 1'b1;
    logic        is_playing = 1'b0;

    int unsigned mismatch_count = 0;
    int unsigned results_checked = 0;
    int unsigned tick_count = 0;
    int unsigned write_count = 0;
    int unsigned start_count = 0;
    int unsigned stop_count = 0;
    int unsigned note_loads = 0;
    int unsigned song_ends = 0;

    melody_note_sequencer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // synchronous reset, held once at the start
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // ---------------------------------------------------------------------
    // note tables and the player model
    // ---------------------------------------------------------------------

    // tone frequency in hz per table index: middle, high, low octave, rest
    function automatic int unsigned note_hz(input logic [4:0] idx);
        case (idx)
            5'd0: return 523;    5'd1: return 587;    5'd2: return 659;
            5'd3: return 698;    5'd4: return 784;    5'd5: return 880;
            5'd6: return 988;    5'd7: return 1047;   5'd8: return 1175;
            5'd9: return 1319;   5'd10: return 1397;  5'd11: return 1568;
            5'd12: return 1760;  5'd13: return 1976;  5'd14: return 262;
            5'd15: return 294;   5'd16: return 330;   5'd17: return 349;
            5'd18: return 392;   5'd19: return 440;   5'd20: return 494;
            default: return 300;
        endcase
    endfunction

    // ticks per half-period of a tone
    function automatic logic [15:0] half_ticks(input logic [4:0] idx);
        return 16'(TICK_HZ / (2 * note_hz(idx)));
    endfunction

    // codes outside the note range play as a rest
    function automatic logic [4:0] tone_index(input logic [7:0] code);
        if (code >= mns_pkg::FIRST_CODE && code <= mns_pkg::LAST_CODE) begin
            return 5'(code - mns_pkg::FIRST_CODE);
        end
        return mns_pkg::REST_IDX;
    endfunction

    // one sequencer step, taken when a half-period runs out while playing
    task automatic sequencer_step(output logic done);
        logic [15:0] entry;
        logic [4:0]  idx;
        int unsigned prod;
        done = 1'b0;
        if (note_count == '0) begin
            entry = tune_mem[play_ptr];
            if (entry[15:8] == mns_pkg::END_CODE) begin
                is_playing = 1'b0;
                tone_en = 1'b0;
                done = 1'b1;
            end else begin
                idx = tone_index(entry[15:8]);
                note_idx = idx;
                half_len = half_ticks(idx);
                prod = note_hz(idx) * entry[7:0];
                note_len = 17'(prod >> 2);
                // sounds for the first three quarters of the note
                sound_len = note_len - (note_len >> 2);
                tone_en = (idx != mns_pkg::REST_IDX);
                note_count = 17'd1;
                note_loads++;
            end
        end else if (note_count >= note_len) begin
            note_count = '0;
            play_ptr = play_ptr + 8'd1;
        end else begin
            note_count = note_count + 17'd1;
            if (note_count == sound_len) begin
                tone_en = 1'b0;
            end
        end
    endtask

    // applies one accepted beat and gives the status it must produce
    task automatic predict_player(input cmd_t c, output status_t s);
        logic done;
        done = 1'b0;
        case (c.op)
            mns_pkg::OP_TICK: begin
                tick_count++;
                if (half_count <= 16'd1) begin
                    half_count = half_len;
                    pin_lvl = tone_en ? ~pin_lvl : 1'b1;
                    if (is_playing) begin
                        sequencer_step(done);
                    end
                end else begin
                    half_count = half_count - 16'd1;
                end
            end
            mns_pkg::OP_WRITE: begin
                write_count++;
                tune_mem[c.addr] = {c.code, c.beat};
            end
            mns_pkg::OP_START: begin
                start_count++;
                play_ptr = c.addr;
                note_count = '0;
                is_playing = 1'b1;
            end
            mns_pkg::OP_STOP: begin
                stop_count++;
                is_playing = 1'b0;
                note_count = '0;
                tone_en = 1'b0;
            end
            default: begin
            end
        endcase
        s.pad = '0;
        s.note = note_idx;
        s.done = done;
        s.playing = is_playing;
        s.tone = tone_en;
        s.level = pin_lvl;
    endtask

    // ---------------------------------------------------------------------
    // driver, sink and monitor
    // ---------------------------------------------------------------------

    function automatic bit source_gap(input logic [1:0] ph);
        case (ph)
            PH_SRC_GAPS:   return $urandom_range(99) < 86;
            PH_BOTH_LIGHT: return $urandom_range(99) < 7;
            default:       return 1'b0;
        endcase
    endfunction

    function automatic bit sink_stall(input logic [1:0] ph);
        case (ph)
            PH_SINK_STALL: return $urandom_range(99) < 86;
            PH_BOTH_LIGHT: return $urandom_range(99) < 7;
            default:       return 1'b0;
        endcase
    endfunction

    // input beats: predict on acceptance, then offer the next one
    always @(posedge aclk) begin : drive
        status_t st;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_player(cur_cmd, st);
                expected_status.push_back(st);
            end
            if (!s_tvalid || s_tready) begin
                if (cmd_backlog.size() != 0 && !source_gap(cmd_backlog[0].phase)) begin
                    cur_cmd = cmd_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {cur_cmd.beat, cur_cmd.code, cur_cmd.addr};
                    s_tuser <= cur_cmd.op;
                    cur_phase <= cur_cmd.phase;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result back-pressure follows the phase of the latest beat sent
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !sink_stall(cur_phase);
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        // keep the log short when something goes badly wrong
        if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] result %0d: %s is %0d, expected %0d",
                     $time, results_checked, what, got, want);
        end
    endtask

    // result beats against the oldest prediction
    always @(posedge aclk) begin : watch
        status_t got;
        status_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = status_t'(m_tdata);
            if (expected_status.size() == 0) begin
                report_mismatch("unexpected result beat, tdata", 32'(m_tdata), 32'd0);
            end else begin
                want = expected_status.pop_front();
                if (got.level !== want.level)
                    report_mismatch("buzzer_level", 32'(got.level), 32'(want.level));
                if (got.tone !== want.tone)
                    report_mismatch("tone_on", 32'(got.tone), 32'(want.tone));
                if (got.playing !== want.playing)
                    report_mismatch("playing", 32'(got.playing), 32'(want.playing));
                if (got.done !== want.done)
                    report_mismatch("song_done", 32'(got.done), 32'(want.done));
                if (got.note !== want.note)
                    report_mismatch("current_note", 32'(got.note), 32'(want.note));
                if (got.pad !== want.pad)
                    report_mismatch("tdata padding", 32'(got.pad), 32'(want.pad));
                if (want.done) begin
                    song_ends++;
                end
            end
            results_checked++;
        end
    end

    // ---------------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------------

    task automatic queue_cmd(input mns_pkg::opcode_t op, input logic [7:0] addr,
                             input logic [7:0] code, input logic [7:0] beat,
                             input logic [1:0] ph);
        cmd_t c;
        c.op = op;
        c.addr = addr;
        c.code = code;
        c.beat = beat;
        c.phase = ph;
        cmd_backlog.push_back(c);
    endtask

    // a run of ticks, now and then broken by a stray write that stays
    // clear of the song entries at the ends of the store
    task automatic queue_ticks(input int unsigned n, input logic [1:0] ph, input bit noisy);
        int unsigned k;
        for (k = 0; k < n; k++) begin
            if (noisy && $urandom_range(99) == 0) begin
                queue_cmd(mns_pkg::OP_WRITE, 8'($urandom_range(254, 1)), 8'($urandom),
                          8'($urandom), ph);
            end
            queue_cmd(mns_pkg::OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom), ph);
        end
    endtask

    initial begin : stimulus
        int unsigned song_ticks;
        int unsigned seg;
        logic [7:0]  song_code;

        // directed: reset values, field extremes, every command
        queue_cmd(mns_pkg::OP_TICK, 8'd0, 8'd0, 8'd0, PH_STEADY);
        queue_cmd(mns_pkg::OP_WRITE, 8'd0, mns_pkg::FIRST_CODE, 8'd0, PH_STEADY);
        queue_cmd(mns_pkg::OP_WRITE, 8'd255, mns_pkg::END_CODE, 8'd255, PH_STEADY);
        queue_cmd(mns_pkg::OP_WRITE, 8'd1, mns_pkg::LAST_CODE, 8'd255, PH_STEADY);
        queue_cmd(mns_pkg::OP_WRITE, 8'd2, 8'd0, 8'd255, PH_STEADY);
        queue_cmd(mns_pkg::OP_WRITE, 8'd3, 8'd23, 8'd1, PH_STEADY);
        queue_cmd(mns_pkg::OP_WRITE, 8'd128, 8'd14, 8'd4, PH_STEADY);
        queue_cmd(mns_pkg::OP_WRITE, 8'd127, 8'd15, 8'd4, PH_STEADY);
        queue_cmd(mns_pkg::OP_START, 8'd255, 8'd255, 8'd255, PH_STEADY);
        queue_ticks(3, PH_STEADY, 1'b0);
        queue_cmd(mns_pkg::OP_STOP, 8'd255, 8'd255, 8'd255, PH_STEADY);
        queue_cmd(mns_pkg::OP_TICK, 8'd255, 8'd255, 8'd255, PH_STEADY);
        queue_cmd(mns_pkg::OP_START, 8'd0, 8'd0, 8'd0, PH_STEADY);
        queue_ticks(2, PH_STEADY, 1'b0);
        // rewrite the entry under the play pointer
        queue_cmd(mns_pkg::OP_WRITE, 8'd0, 8'd21, 8'd2, PH_STEADY);
        queue_cmd(mns_pkg::OP_STOP, 8'd0, 8'd0, 8'd0, PH_STEADY);
        queue_cmd(mns_pkg::OP_TICK, 8'd0, 8'd0, 8'd0, PH_STEADY);

        // a zero-length top note at the last address, the end marker at
        // address zero, so the play pointer wraps on the way
        song_code = 8'd14;
        queue_cmd(mns_pkg::OP_WRITE, 8'd255, song_code, 8'd0, PH_STEADY);
        queue_cmd(mns_pkg::OP_WRITE, 8'd0, mns_pkg::END_CODE, 8'($urandom), PH_STEADY);
        queue_cmd(mns_pkg::OP_START, 8'd255, 8'($urandom), 8'($urandom), PH_STEADY);

        // load on the first expiry, note end one reset half-period later,
        // end marker one note half-period after that
        song_ticks = (32'(mns_pkg::HALF_RESET) - DIRECTED_TICKS) + 32'(mns_pkg::HALF_RESET)
                     + 32'(half_ticks(tone_index(song_code))) + TAIL_TICKS;
        seg = song_ticks / 4;
        queue_ticks(seg, PH_STEADY, 1'b1);
        queue_ticks(seg, PH_SRC_GAPS, 1'b1);
        queue_ticks(seg, PH_SINK_STALL, 1'b1);
        queue_ticks(song_ticks - 3 * seg, PH_BOTH_LIGHT, 1'b1);

        // stop and restart on a written entry, then stop again
        queue_cmd(mns_pkg::OP_STOP, 8'($urandom), 8'($urandom), 8'($urandom), PH_BOTH_LIGHT);
        queue_cmd(mns_pkg::OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom), PH_BOTH_LIGHT);
        queue_cmd(mns_pkg::OP_START, 8'd255, 8'($urandom), 8'($urandom), PH_BOTH_LIGHT);
        queue_ticks(TAIL_TICKS, PH_BOTH_LIGHT, 1'b0);
        queue_cmd(mns_pkg::OP_STOP, 8'($urandom), 8'($urandom), 8'($urandom), PH_BOTH_LIGHT);

        // wait for the last beat to go in and its result to come out
        wait (aresetn);
        while (cmd_backlog.size() != 0 || s_tvalid) @(negedge aclk);
        while (expected_status.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("drove %0d ticks, %0d song writes, %0d starts and %0d stops",
                 tick_count, write_count, start_count, stop_count);
        $display("checked %0d result beats over %0d note loads, %0d songs ran to the end",
                 results_checked, note_loads, song_ends);
        if (mismatch_count == 0 && expected_status.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // hard stop if the flow hangs
    initial begin
        #(RUN_LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule
